// File: rtl/core/pgr_pkg.sv
`default_nettype none

package pgr_pkg;

    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 4;
    localparam int KIND_W  = 3;
    localparam int STATE_W = 3;
    localparam int THR_W   = 33;
    localparam int IDX_W   = 2;

    // primary point states
    localparam logic [STATE_W-1:0] ST_DOWN        = 3'd0;
    localparam logic [STATE_W-1:0] ST_UP          = 3'd1;
    localparam logic [STATE_W-1:0] ST_MOTION      = 3'd2;
    localparam logic [STATE_W-1:0] ST_STATIONARY  = 3'd3;
    localparam logic [STATE_W-1:0] ST_INTERRUPTED = 3'd4;

    // gesture report kinds
    localparam logic [KIND_W-1:0] K_POSSIBLE   = 3'd0;
    localparam logic [KIND_W-1:0] K_STARTED    = 3'd1;
    localparam logic [KIND_W-1:0] K_CONTINUING = 3'd2;
    localparam logic [KIND_W-1:0] K_FINISHED   = 3'd3;
    localparam logic [KIND_W-1:0] K_CANCELLED  = 3'd4;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_MIN_TOUCHES  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_TOUCHES  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_THRESHOLD_SQ = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_SQ_RESET = 33'd25600;

    typedef struct packed {
        logic [CNT_W-1:0] min_touches;
        logic [CNT_W-1:0] max_touches;
        logic [THR_W-1:0] threshold_sq;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic signed [POS_W-1:0] prev_x;
        logic signed [POS_W-1:0] prev_y;
        logic [TIME_W-1:0]       time_delta;
        logic [CNT_W-1:0]        touch_count;
        logic [TIME_W-1:0]       report_time;
        logic                    last;
    } report_t;

    typedef struct packed {
        logic [1:0] n;
        report_t    r0;
        report_t    r1;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/pan_gesture_recognizer.sv
// Pan gesture recognizer.
// Input stream: one touch event per beat on s_*; output stream: gesture reports
// on m_*, zero to two per event, m_tlast set on the final report of an event.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// min_touches (0), max_touches (1) or motion_threshold_sq (2); other indexes
// are dropped. Write only while no event is in flight.
// Timing: in the front end an event goes through the squared distance from
// the touch-down point, then the phase decision, so s_tready drops after every
// accepted beat and no new event is taken until the decision is done. The
// decision pushes the reports of an event, a second one behind the first, into
// a QUEUE_DEPTH-entry queue ahead of an output register that drives m_*, so the
// input keeps flowing while m_tready is low until the queue cannot take two
// more reports; then s_tready stays low.
// Reset (aresetn low, synchronous): phase clear, history empty, registers at
// min 1, max 1, threshold 25600, queue and output register empty.
`default_nettype none

module pan_gesture_recognizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_count, pos_x, pos_y, event_time, secondary_up, zero fill
    input  wire logic [71:0]  s_tdata,
    // primary_state
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cur_x, cur_y, prev_x, prev_y, time_delta, touch_count, report_time, zero fill
    output logic [135:0]      m_tdata,
    // gesture_kind
    output logic [2:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [pgr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [pgr_pkg::THR_W-1:0] cfg_data
);
    import pgr_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    push_t   push;
    logic    room2;
    logic    q_valid, q_ready;
    report_t q_rep, m_rep;

    assign cfg_ready = aresetn;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_TOUCHES:  cfg_next.min_touches  = cfg_data[CNT_W-1:0];
                CFG_MAX_TOUCHES:  cfg_next.max_touches  = cfg_data[CNT_W-1:0];
                CFG_THRESHOLD_SQ: cfg_next.threshold_sq = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_touches  <= 4'd1;
            cfg_reg.max_touches  <= 4'd1;
            cfg_reg.threshold_sq <= THRESHOLD_SQ_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pgr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_state (s_tuser),
        .in_count (s_tdata[3:0]),
        .in_x     ($signed(s_tdata[19:4])),
        .in_y     ($signed(s_tdata[35:20])),
        .in_time  (s_tdata[67:36]),
        .in_sec   (s_tdata[68]),
        .room2    (room2),
        .push     (push)
    );

    pgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room2     (room2),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rep   (q_rep)
    );

    pgr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_rep    (q_rep),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rep   (m_rep)
    );

    assign m_tdata = {4'b0, m_rep.report_time, m_rep.touch_count, m_rep.time_delta,
                      m_rep.prev_y, m_rep.prev_x, m_rep.cur_y, m_rep.cur_x};
    assign m_tuser = m_rep.kind;
    assign m_tlast = m_rep.last;

`ifndef NO_ASSERTIONS
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_push_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> $past(s_tvalid && s_tready))
        else $error("reports pushed without an accepted event");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> (!push.r0.last && push.r1.last))
        else $error("last flag wrong on a report pair");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd1 |-> push.r0.last)
        else $error("last flag missing on a single report");
`endif

endmodule

`default_nettype wire

// File: rtl/core/pgr_front.sv
`default_nettype none

module pgr_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire pgr_pkg::cfg_t                  cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [pgr_pkg::STATE_W-1:0]    in_state,
    input  wire logic [pgr_pkg::CNT_W-1:0]      in_count,
    input  wire logic signed [pgr_pkg::POS_W-1:0] in_x,
    input  wire logic signed [pgr_pkg::POS_W-1:0] in_y,
    input  wire logic [pgr_pkg::TIME_W-1:0]     in_time,
    input  wire logic                           in_sec,
    input  wire logic                           room2,
    output pgr_pkg::push_t                      push
);
    import pgr_pkg::*;

    typedef enum logic [2:0] {
        PH_CLEAR,
        PH_POSSIBLE,
        PH_STARTED,
        PH_FINISHED,
        PH_FAILED
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    busy_reg;
    logic [1:0]              hist_reg, hist_next, hist_post;
    logic signed [POS_W-1:0] down_x_reg, down_y_reg, down_x_next, down_y_next;
    logic [TIME_W-1:0]       down_time_reg, down_time_next;
    logic signed [POS_W-1:0] newest_x_reg, newest_y_reg, newest_x_next, newest_y_next;
    logic [TIME_W-1:0]       newest_time_reg, newest_time_next;
    logic signed [POS_W-1:0] older_x_reg, older_y_reg, older_x_next, older_y_next;
    logic [TIME_W-1:0]       older_time_reg, older_time_next;

    logic [STATE_W-1:0]      ev_state_reg;
    logic [CNT_W-1:0]        ev_count_reg;
    logic signed [POS_W-1:0] ev_x_reg, ev_y_reg;
    logic [TIME_W-1:0]       ev_time_reg;
    logic                    ev_sec_reg;
    logic [31:0]             sqx_reg, sqy_reg;

    logic                    accept;
    logic signed [POS_W:0]   dx, dy;
    logic signed [2*POS_W+1:0] px, py;
    logic                    moved, in_range, sec_up;
    logic                    rec, clr, set_down;
    logic [1:0]              n_rep;
    report_t                 rep0, rep1;

    function automatic report_t mk_rep(
        input logic [KIND_W-1:0]       kind,
        input logic [1:0]              hist,
        input logic signed [POS_W-1:0] ox,
        input logic signed [POS_W-1:0] oy,
        input logic [TIME_W-1:0]       ot,
        input logic signed [POS_W-1:0] dnx,
        input logic signed [POS_W-1:0] dny,
        input logic [TIME_W-1:0]       dnt,
        input logic signed [POS_W-1:0] ex,
        input logic signed [POS_W-1:0] ey,
        input logic [TIME_W-1:0]       et,
        input logic [CNT_W-1:0]        ec
    );
        report_t r;
        r.kind        = kind;
        r.cur_x       = ex;
        r.cur_y       = ey;
        r.prev_x      = ex;
        r.prev_y      = ey;
        r.time_delta  = '0;
        r.touch_count = ec;
        r.report_time = et;
        r.last        = 1'b1;
        if (hist == 2'd2) begin
            if (kind == K_STARTED) begin
                r.prev_x     = dnx;
                r.prev_y     = dny;
                r.time_delta = et - dnt;
            end else begin
                r.prev_x     = ox;
                r.prev_y     = oy;
                r.time_delta = et - ot;
            end
        end
        return r;
    endfunction

    assign in_ready = aresetn && !busy_reg && room2;
    assign accept   = in_valid && in_ready;

    // squared distance from touch-down, first half of the event
    always_comb begin
        dx = $signed({in_x[POS_W-1], in_x}) - $signed({down_x_reg[POS_W-1], down_x_reg});
        dy = $signed({in_y[POS_W-1], in_y}) - $signed({down_y_reg[POS_W-1], down_y_reg});
        px = dx * dx;
        py = dy * dy;
    end

    assign moved    = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) >= cfg.threshold_sq;
    assign in_range = (ev_count_reg >= cfg.min_touches) && (ev_count_reg <= cfg.max_touches);
    assign sec_up   = ev_sec_reg && (ev_count_reg >= 4'd2);
    assign hist_post = (hist_reg == 2'd2) ? 2'd2 : hist_reg + 2'd1;

    always_comb begin
        phase_next = phase_reg;
        rec        = 1'b0;
        clr        = 1'b0;
        set_down   = 1'b0;
        n_rep      = 2'd0;
        rep0       = '0;
        rep1       = '0;
        if (ev_state_reg == ST_INTERRUPTED) begin
            if (phase_reg == PH_STARTED || phase_reg == PH_POSSIBLE) begin
                rec   = 1'b1;
                rep0  = mk_rep(K_CANCELLED, hist_post, newest_x_reg, newest_y_reg,
                               newest_time_reg, down_x_reg, down_y_reg, down_time_reg,
                               ev_x_reg, ev_y_reg, ev_time_reg, ev_count_reg);
                n_rep = 2'd1;
            end
            phase_next = PH_CLEAR;
            clr        = 1'b1;
        end else begin
            case (phase_reg)
                PH_CLEAR: begin
                    if (ev_state_reg == ST_DOWN) begin
                        set_down = 1'b1;
                        rec      = 1'b1;
                        if (ev_count_reg == cfg.min_touches) begin
                            phase_next = PH_POSSIBLE;
                            rep0  = mk_rep(K_POSSIBLE, hist_reg, older_x_reg, older_y_reg,
                                           older_time_reg, down_x_reg, down_y_reg,
                                           down_time_reg, ev_x_reg, ev_y_reg, ev_time_reg,
                                           ev_count_reg);
                            n_rep = 2'd1;
                        end
                    end
                end
                PH_POSSIBLE: begin
                    if (in_range) begin
                        if (ev_state_reg == ST_MOTION) begin
                            rec = 1'b1;
                            if (moved) begin
                                phase_next = PH_STARTED;
                                rep0  = mk_rep(K_STARTED, hist_post, newest_x_reg,
                                               newest_y_reg, newest_time_reg, down_x_reg,
                                               down_y_reg, down_time_reg, ev_x_reg,
                                               ev_y_reg, ev_time_reg, ev_count_reg);
                                n_rep = 2'd1;
                            end
                        end else if (ev_state_reg == ST_UP) begin
                            if (moved) begin
                                rep0 = mk_rep(K_STARTED, hist_reg, older_x_reg, older_y_reg,
                                              older_time_reg, down_x_reg, down_y_reg,
                                              down_time_reg, ev_x_reg, ev_y_reg,
                                              ev_time_reg, ev_count_reg);
                                rep0.last = 1'b0;
                                rec  = 1'b1;
                                rep1 = mk_rep(K_FINISHED, hist_post, newest_x_reg,
                                              newest_y_reg, newest_time_reg, down_x_reg,
                                              down_y_reg, down_time_reg, ev_x_reg,
                                              ev_y_reg, ev_time_reg, ev_count_reg);
                                n_rep = 2'd2;
                            end else begin
                                rep0  = mk_rep(K_CANCELLED, hist_reg, older_x_reg,
                                               older_y_reg, older_time_reg, down_x_reg,
                                               down_y_reg, down_time_reg, ev_x_reg,
                                               ev_y_reg, ev_time_reg, ev_count_reg);
                                n_rep = 2'd1;
                            end
                            phase_next = PH_CLEAR;
                            clr        = 1'b1;
                        end
                    end else begin
                        rep0  = mk_rep(K_CANCELLED, hist_reg, older_x_reg, older_y_reg,
                                       older_time_reg, down_x_reg, down_y_reg,
                                       down_time_reg, ev_x_reg, ev_y_reg, ev_time_reg,
                                       ev_count_reg);
                        n_rep = 2'd1;
                        if (ev_count_reg == 4'd1 && ev_state_reg == ST_UP) begin
                            phase_next = PH_CLEAR;
                            clr        = 1'b1;
                        end else begin
                            phase_next = PH_FAILED;
                        end
                    end
                end
                PH_STARTED: begin
                    rec = 1'b1;
                    if (in_range) begin
                        if (ev_state_reg == ST_MOTION) begin
                            rep0  = mk_rep(K_CONTINUING, hist_post, newest_x_reg,
                                           newest_y_reg, newest_time_reg, down_x_reg,
                                           down_y_reg, down_time_reg, ev_x_reg, ev_y_reg,
                                           ev_time_reg, ev_count_reg);
                            n_rep = 2'd1;
                        end else if (ev_state_reg == ST_UP) begin
                            rep0  = mk_rep(K_FINISHED, hist_post, newest_x_reg,
                                           newest_y_reg, newest_time_reg, down_x_reg,
                                           down_y_reg, down_time_reg, ev_x_reg, ev_y_reg,
                                           ev_time_reg, ev_count_reg);
                            n_rep = 2'd1;
                            phase_next = PH_CLEAR;
                            clr        = 1'b1;
                        end else if (ev_state_reg == ST_STATIONARY) begin
                            if (ev_count_reg == cfg.min_touches && sec_up) begin
                                rep0  = mk_rep(K_FINISHED, hist_post, newest_x_reg,
                                               newest_y_reg, newest_time_reg, down_x_reg,
                                               down_y_reg, down_time_reg, ev_x_reg,
                                               ev_y_reg, ev_time_reg, ev_count_reg);
                                n_rep = 2'd1;
                                phase_next = PH_FINISHED;
                            end
                        end
                    end else begin
                        rep0  = mk_rep(K_FINISHED, hist_post, newest_x_reg, newest_y_reg,
                                       newest_time_reg, down_x_reg, down_y_reg,
                                       down_time_reg, ev_x_reg, ev_y_reg, ev_time_reg,
                                       ev_count_reg);
                        n_rep = 2'd1;
                        if (ev_count_reg == 4'd1 && ev_state_reg == ST_UP) begin
                            phase_next = PH_CLEAR;
                            clr        = 1'b1;
                        end else begin
                            phase_next = PH_FINISHED;
                        end
                    end
                end
                default: begin
                    if (ev_state_reg == ST_UP) begin
                        phase_next = PH_CLEAR;
                        clr        = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        hist_next        = hist_reg;
        newest_x_next    = newest_x_reg;
        newest_y_next    = newest_y_reg;
        newest_time_next = newest_time_reg;
        older_x_next     = older_x_reg;
        older_y_next     = older_y_reg;
        older_time_next  = older_time_reg;
        down_x_next      = down_x_reg;
        down_y_next      = down_y_reg;
        down_time_next   = down_time_reg;
        if (set_down) begin
            down_x_next    = ev_x_reg;
            down_y_next    = ev_y_reg;
            down_time_next = ev_time_reg;
        end
        if (rec) begin
            older_x_next     = newest_x_reg;
            older_y_next     = newest_y_reg;
            older_time_next  = newest_time_reg;
            newest_x_next    = ev_x_reg;
            newest_y_next    = ev_y_reg;
            newest_time_next = ev_time_reg;
            hist_next        = hist_post;
        end
        if (clr) begin
            hist_next = 2'd0;
        end
    end

    always_comb begin
        push.n  = busy_reg ? n_rep : 2'd0;
        push.r0 = rep0;
        push.r1 = rep1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CLEAR;
            busy_reg  <= 1'b0;
            hist_reg  <= 2'd0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
            end
            if (busy_reg) begin
                phase_reg <= phase_next;
                hist_reg  <= hist_next;
            end
        end
        if (accept) begin
            ev_state_reg <= in_state;
            ev_count_reg <= in_count;
            ev_x_reg     <= in_x;
            ev_y_reg     <= in_y;
            ev_time_reg  <= in_time;
            ev_sec_reg   <= in_sec;
            sqx_reg      <= px[31:0];
            sqy_reg      <= py[31:0];
        end
        if (busy_reg) begin
            down_x_reg      <= down_x_next;
            down_y_reg      <= down_y_next;
            down_time_reg   <= down_time_next;
            newest_x_reg    <= newest_x_next;
            newest_y_reg    <= newest_y_next;
            newest_time_reg <= newest_time_next;
            older_x_reg     <= older_x_next;
            older_y_reg     <= older_y_next;
            older_time_reg  <= older_time_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pgr_queue.sv
`default_nettype none

module pgr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pgr_pkg::push_t   push,
    output logic                  room2,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pgr_pkg::report_t      out_rep
);
    import pgr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    report_t         mem [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next, wr_p1, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign out_valid = (cnt_reg != '0);
    assign out_rep   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = (cnt_reg <= CW'(DEPTH - 2));

    always_comb begin
        wr_p1 = ptr_inc(wr_reg);
        case (push.n)
            2'd1:    wr_next = wr_p1;
            2'd2:    wr_next = ptr_inc(wr_p1);
            default: wr_next = wr_reg;
        endcase
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wr_p1] <= push.r1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pgr_back.sv
`default_nettype none

module pgr_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pgr_pkg::report_t  in_rep,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pgr_pkg::report_t       out_rep
);
    import pgr_pkg::*;

    logic    valid_reg;
    report_t rep_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rep   = rep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            rep_reg <= in_rep;
        end
    end

endmodule

`default_nettype wire
